/* hdl/oha_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oha_pkg
// Shared types, widths and codes for the orbital Hessian apply block.
// ----------------------------------------------------------------------------
package oha_pkg;

    localparam int MaxOrbitals = 8;
    localparam int MaxPairs    = 16;
    localparam int OrbW        = 3;
    localparam int PairW       = 4;
    localparam int CountW      = 4;
    localparam int ValW        = 32;
    localparam int IntAddrW    = 4 * OrbW;
    localparam int CoefW       = 36;
    localparam int AccW        = 64;
    localparam int CfgIdxW     = 1;

    typedef enum logic [2:0] {
        OP_LOAD_INT  = 3'd0,
        OP_LOAD_EN   = 3'd1,
        OP_LOAD_TR   = 3'd2,
        OP_APPLY     = 3'd3,
        OP_PRECOND   = 3'd4
    } op_t;

    localparam logic [CfgIdxW-1:0] CFG_NUM_OCC  = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_NUM_VIRT = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic              clr_acc;     // start a new sum
        logic              rd_diag;     // fetch energies and x[ia]
        logic              rd_g;        // fetch integral
        logic [1:0]        g_sel;       // which of the three integrals
        logic              rd_x;        // fetch x[jb]
        logic              mul_diag;    // multiply diagonal term
        logic              mul_coef;    // multiply coefficient term
        logic              add_prod;    // accumulate product
        logic [OrbW-1:0]   i;
        logic [OrbW-1:0]   a;
        logic [OrbW-1:0]   j;
        logic [OrbW-1:0]   b;
    } dp_cmd_t;

    typedef struct packed {
        logic [ValW-1:0] diag_sat;
        logic [ValW-1:0] acc_sat;
    } dp_stat_t;

endpackage

/* hdl/oha_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oha_in_if / oha_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface oha_in_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   operation;
    logic [oha_pkg::OrbW-1:0]     orb_p;
    logic [oha_pkg::OrbW-1:0]     orb_q;
    logic [oha_pkg::OrbW-1:0]     orb_r;
    logic [oha_pkg::OrbW-1:0]     orb_s;
    logic [oha_pkg::PairW-1:0]    pair_index;
    logic signed [oha_pkg::ValW-1:0] load_value;
    modport source (output valid, operation, orb_p, orb_q, orb_r, orb_s, pair_index,
                    load_value, input ready);
    modport sink (input valid, operation, orb_p, orb_q, orb_r, orb_s, pair_index,
                  load_value, output ready);
endinterface

interface oha_out_if;
    logic                         valid;
    logic                         ready;
    logic signed [oha_pkg::ValW-1:0] result_value;
    logic [oha_pkg::PairW-1:0]    result_index;
    logic                         last;
    logic                         layout_error;
    modport source (output valid, result_value, result_index, last, layout_error,
                    input ready);
    modport sink (input valid, result_value, result_index, last, layout_error,
                  output ready);
endinterface

/* hdl/oha_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oha_datapath
// Stores, coefficient build, two partial-product multipliers and the 64-bit accumulator.
// ----------------------------------------------------------------------------
module oha_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_int,
    input  logic                          wr_en_e,
    input  logic                          wr_tr,
    input  logic [oha_pkg::IntAddrW-1:0]  wr_int_addr,
    input  logic [oha_pkg::OrbW-1:0]      wr_orb,
    input  logic [oha_pkg::PairW-1:0]     wr_pair,
    input  logic [oha_pkg::ValW-1:0]      wr_data,
    input  logic [oha_pkg::CountW-1:0]    nocc,
    input  logic [oha_pkg::CountW-1:0]    nvir,
    input  oha_pkg::dp_cmd_t              cmd,
    output oha_pkg::dp_stat_t             stat
);
    localparam int MulW = oha_pkg::CoefW + oha_pkg::ValW - 12;

    logic [oha_pkg::ValW-1:0] int_mem [0:(1 << oha_pkg::IntAddrW)-1];
    logic [oha_pkg::ValW-1:0] en_mem  [0:oha_pkg::MaxOrbitals-1];
    logic [oha_pkg::ValW-1:0] tr_mem  [0:oha_pkg::MaxPairs-1];

    logic [oha_pkg::ValW-1:0] g_rd_reg;
    logic [oha_pkg::ValW-1:0] ea_reg, ei_reg, xd_reg, x_reg;
    logic [1:0]               g_sel_reg;
    logic                     g_vld_reg;
    logic signed [oha_pkg::CoefW-1:0] coef_reg, coef_next;
    logic signed [oha_pkg::CoefW-1:0] diag_reg;
    logic signed [MulW-1:0]   ph_reg, pl_reg;
    logic signed [oha_pkg::AccW-1:0] acc_reg;

    logic [oha_pkg::OrbW-1:0] va, vb;
    logic [oha_pkg::OrbW-1:0] gp, gq, gr, gs;
    logic [oha_pkg::PairW+oha_pkg::CountW-1:0] ia_w, jb_w;
    logic signed [oha_pkg::ValW-1:0] xm;
    logic signed [oha_pkg::CoefW-1:0] cm;
    logic signed [oha_pkg::ValW-13:0] xh;
    logic signed [12:0] xl;
    logic signed [MulW-1:0] sum_prod;
    logic signed [oha_pkg::AccW-1:0] prod64;

    assign va = oha_pkg::OrbW'(nocc + {1'b0, cmd.a});
    assign vb = oha_pkg::OrbW'(nocc + {1'b0, cmd.b});
    assign ia_w = cmd.i * nvir + {5'd0, cmd.a};
    assign jb_w = cmd.j * nvir + {5'd0, cmd.b};

    always_comb
    begin
        gp = va;
        unique case (cmd.g_sel)
            2'd0:    begin gq = cmd.i; gr = vb;    gs = cmd.j; end
            2'd1:    begin gq = vb;    gr = cmd.i; gs = cmd.j; end
            default: begin gq = cmd.j; gr = cmd.i; gs = vb;    end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_int)
            int_mem[wr_int_addr] <= wr_data;
        if (wr_en_e)
            en_mem[wr_orb] <= wr_data;
        if (wr_tr)
            tr_mem[wr_pair] <= wr_data;
        g_rd_reg <= int_mem[{gp, gq, gr, gs}];
        if (cmd.rd_diag)
        begin
            ea_reg <= en_mem[va];
            ei_reg <= en_mem[cmd.i];
            xd_reg <= tr_mem[ia_w[oha_pkg::PairW-1:0]];
        end
        if (cmd.rd_x)
            x_reg <= tr_mem[jb_w[oha_pkg::PairW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_vld_reg <= 1'b0;
            g_sel_reg <= 2'd0;
        end
        else
        begin
            g_vld_reg <= cmd.rd_g;
            g_sel_reg <= cmd.g_sel;
        end
    end

    // fold the three integrals into 4*g1 - g2 - g3 as they arrive
    always_comb
    begin
        coef_next = coef_reg;
        if (g_vld_reg)
        begin
            unique case (g_sel_reg)
                2'd0:    coef_next = $signed({{2{g_rd_reg[31]}}, g_rd_reg, 2'b00});
                default: coef_next = coef_reg
                                     - oha_pkg::CoefW'($signed(g_rd_reg));
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
        diag_reg <= oha_pkg::CoefW'($signed(ea_reg)) - oha_pkg::CoefW'($signed(ei_reg));
    end

    // split x into high 20-bit and low 12-bit parts so each partial product stays exact
    always_comb
    begin
        if (cmd.mul_diag)
        begin
            cm = diag_reg;
            xm = $signed(xd_reg);
        end
        else
        begin
            cm = coef_reg;
            xm = $signed(x_reg);
        end
        xh = $signed(xm[oha_pkg::ValW-1:12]);
        xl = $signed({1'b0, xm[11:0]});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_diag || cmd.mul_coef)
        begin
            ph_reg <= MulW'(cm) * MulW'(xh);
            pl_reg <= MulW'(cm) * MulW'(xl);
        end
    end

    assign sum_prod = ph_reg + (pl_reg >>> 12);
    assign prod64   = oha_pkg::AccW'(sum_prod >>> 12);

    always_ff @(posedge clk)
    begin
        if (cmd.clr_acc)
            acc_reg <= '0;
        else if (cmd.add_prod)
            acc_reg <= acc_reg + prod64;
    end

    function automatic logic [oha_pkg::ValW-1:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        else if (v < -64'sd2147483648)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

    assign stat.acc_sat  = sat32(acc_reg);
    assign stat.diag_sat = sat32(64'(diag_reg));
endmodule

/* hdl/oha_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oha_ctrl
// Sequencer: takes items, walks pairs and terms, drives the output register.
// ----------------------------------------------------------------------------
module oha_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    oha_in_if.sink                     in_ch,
    oha_out_if.source                  out_ch,
    input  logic [oha_pkg::CountW-1:0] nocc,
    input  logic [oha_pkg::CountW-1:0] nvir,
    output logic                       wr_int,
    output logic                       wr_en_e,
    output logic                       wr_tr,
    output oha_pkg::dp_cmd_t           cmd,
    input  oha_pkg::dp_stat_t          stat
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIAG  = 7'b0000010,
        S_DMUL  = 7'b0000100,
        S_TERM  = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_WAIT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   apply_reg, apply_next;
    logic [oha_pkg::OrbW-1:0] i_reg, i_next, a_reg, a_next, j_reg, j_next, b_reg, b_next;
    logic [1:0] g_reg, g_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [2:0] pipe_reg, pipe_next;   // delayed term issue: coef, mul, add
    logic       ovalid_reg, ovalid_next, olast_reg, olast_next, oerr_reg, oerr_next;
    logic [oha_pkg::ValW-1:0]   oval_reg, oval_next;
    logic [oha_pkg::PairW-1:0]  oidx_reg, oidx_next;
    logic       is_load, is_run, bad_layout, last_pair, last_term, out_free;
    logic [oha_pkg::CountW:0] osum;
    logic [2*oha_pkg::CountW-1:0] oprod;
    logic [2*oha_pkg::CountW-1:0] ia_full;

    assign osum  = {1'b0, nocc} + {1'b0, nvir};
    assign oprod = nocc * nvir;
    assign bad_layout = (nocc == '0) || (nvir == '0)
                        || (osum > (oha_pkg::CountW+1)'(oha_pkg::MaxOrbitals))
                        || (oprod > (2*oha_pkg::CountW)'(oha_pkg::MaxPairs));
    assign is_load = (in_ch.operation == oha_pkg::OP_LOAD_INT)
                     || (in_ch.operation == oha_pkg::OP_LOAD_EN)
                     || (in_ch.operation == oha_pkg::OP_LOAD_TR);
    assign is_run  = (in_ch.operation == oha_pkg::OP_APPLY)
                     || (in_ch.operation == oha_pkg::OP_PRECOND);
    assign out_free = !ovalid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && (!is_run || out_free);

    assign wr_int  = in_ch.valid && in_ch.ready && (in_ch.operation == oha_pkg::OP_LOAD_INT);
    assign wr_en_e = in_ch.valid && in_ch.ready && (in_ch.operation == oha_pkg::OP_LOAD_EN);
    assign wr_tr   = in_ch.valid && in_ch.ready && (in_ch.operation == oha_pkg::OP_LOAD_TR);

    assign last_pair = ({1'b0, i_reg} == nocc - 1'b1) && ({1'b0, a_reg} == nvir - 1'b1);
    assign last_term = ({1'b0, j_reg} == nocc - 1'b1) && ({1'b0, b_reg} == nvir - 1'b1)
                       && (g_reg == 2'd2);
    assign ia_full = i_reg * nvir + {5'd0, a_reg};

    always_comb
    begin
        state_next  = state_reg;
        apply_next  = apply_reg;
        i_next = i_reg; a_next = a_reg; j_next = j_reg; b_next = b_reg;
        g_next = g_reg; cnt_next = cnt_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        olast_next  = olast_reg; oerr_next = oerr_reg;
        oval_next   = oval_reg;  oidx_next = oidx_reg;
        pipe_next   = {pipe_reg[1:0], 1'b0};
        cmd = '0;
        cmd.i = i_reg; cmd.a = a_reg; cmd.j = j_reg; cmd.b = b_reg; cmd.g_sel = g_reg;
        cmd.add_prod = pipe_reg[2];
        cmd.mul_coef = pipe_reg[1];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready && is_run && !is_load)
                begin
                    apply_next = (in_ch.operation == oha_pkg::OP_APPLY);
                    i_next = '0; a_next = '0;
                    if (bad_layout)
                    begin
                        ovalid_next = 1'b1; oval_next = '0; oidx_next = '0;
                        olast_next = 1'b1; oerr_next = 1'b1;
                    end
                    else
                        state_next = S_DIAG;
                end
            end
            S_DIAG:
            begin
                cmd.rd_diag = 1'b1;
                cnt_next = 3'd0;
                state_next = S_DMUL;
            end
            S_DMUL:
            begin
                // energy diff registered, then multiply
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd1)
                begin
                    cmd.clr_acc = 1'b1;
                    if (apply_next)
                    begin
                        cmd.mul_diag = 1'b1;
                        j_next = '0; b_next = '0; g_next = 2'd0;
                        state_next = S_TERM;
                    end
                    else
                        state_next = S_EMIT;
                end
            end
            S_TERM:
            begin
                if (cnt_reg == 3'd2)
                    cmd.add_prod = 1'b1;   // diagonal product
                cnt_next = 3'd0;
                cmd.rd_g = 1'b1;
                if (g_reg == 2'd2)
                begin
                    cmd.rd_x = 1'b1;
                    pipe_next[0] = 1'b1;
                    g_next = 2'd0;
                    if (last_term)
                    begin
                        cnt_next = 3'd0;
                        state_next = S_DRAIN;
                    end
                    else if ({1'b0, b_reg} == nvir - 1'b1)
                    begin
                        b_next = '0; j_next = j_reg + 1'b1;
                    end
                    else
                        b_next = b_reg + 1'b1;
                end
                else
                    g_next = g_reg + 2'd1;
            end
            S_DRAIN:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    oval_next = apply_reg ? stat.acc_sat : stat.diag_sat;
                    oidx_next = ia_full[oha_pkg::PairW-1:0];
                    olast_next = last_pair;
                    oerr_next = 1'b0;
                    if (last_pair)
                        state_next = S_IDLE;
                    else
                    begin
                        if ({1'b0, a_reg} == nvir - 1'b1)
                        begin
                            a_next = '0; i_next = i_reg + 1'b1;
                        end
                        else
                            a_next = a_reg + 1'b1;
                        state_next = S_DIAG;
                    end
                end
            end
            S_WAIT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_DMUL && cnt_reg == 3'd1 && apply_reg)
            cnt_next = 3'd2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; apply_reg <= 1'b0;
            i_reg <= '0; a_reg <= '0; j_reg <= '0; b_reg <= '0;
            g_reg <= '0; cnt_reg <= '0; pipe_reg <= '0;
            ovalid_reg <= 1'b0; olast_reg <= 1'b0; oerr_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; apply_reg <= apply_next;
            i_reg <= i_next; a_reg <= a_next; j_reg <= j_next; b_reg <= b_next;
            g_reg <= g_next; cnt_reg <= cnt_next; pipe_reg <= pipe_next;
            ovalid_reg <= ovalid_next; olast_reg <= olast_next; oerr_reg <= oerr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oval_reg <= oval_next;
        oidx_reg <= oidx_next;
    end

    assign out_ch.valid        = ovalid_reg;
    assign out_ch.result_value = oval_reg;
    assign out_ch.result_index = oidx_reg;
    assign out_ch.last         = olast_reg;
    assign out_ch.layout_error = oerr_reg;
endmodule

/* hdl/orbital_hessian_apply_core.sv */
`timescale 1ns / 1ps
// Loads: one per cycle while idle, no result. Precondition: one result per pair.
// Apply: one result per pair while the output is free, paced by the single
// integral read port (three integral words per term). Layout error: one result.
// Reset: asynchronous, active low; counts return to 1, stores hold undefined data.
// ----------------------------------------------------------------------------
// orbital_hessian_apply_core
// Top level: configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
module orbital_hessian_apply_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    oha_in_if.sink                         in_ch,
    oha_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [oha_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [oha_pkg::CountW-1:0]     cfg_data
);
    logic [oha_pkg::CountW-1:0] nocc_reg, nvir_reg;
    logic wr_int, wr_en_e, wr_tr;
    oha_pkg::dp_cmd_t  cmd;
    oha_pkg::dp_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nocc_reg <= oha_pkg::CountW'(1);
            nvir_reg <= oha_pkg::CountW'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == oha_pkg::CFG_NUM_OCC)
                nocc_reg <= cfg_data;
            else
                nvir_reg <= cfg_data;
        end
    end

    oha_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .nocc(nocc_reg), .nvir(nvir_reg),
        .wr_int(wr_int), .wr_en_e(wr_en_e), .wr_tr(wr_tr),
        .cmd(cmd), .stat(stat)
    );

    oha_datapath u_dp
    (
        .clk(clk), .rst_n(rst_n),
        .wr_int(wr_int), .wr_en_e(wr_en_e), .wr_tr(wr_tr),
        .wr_int_addr({in_ch.orb_p, in_ch.orb_q, in_ch.orb_r, in_ch.orb_s}),
        .wr_orb(in_ch.orb_p), .wr_pair(in_ch.pair_index), .wr_data(in_ch.load_value),
        .nocc(nocc_reg), .nvir(nvir_reg), .cmd(cmd), .stat(stat)
    );
endmodule

/* hdl/oha_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oha_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module oha_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_value,
    input logic        out_last,
    input logic        out_err,
    input logic [3:0]  out_index
);
    // a stalled transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value))
        else $error("result changed while stalled");

    // index and flags hold with the value
    a_hold_tag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_index) && $stable(out_last)
                                    && $stable(out_err))
        else $error("result tag changed while stalled");

    // an error result is a final, zero transaction
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_err |-> out_last && out_index == 4'd0 && out_value == 32'd0)
        else $error("malformed error result");
endmodule

bind orbital_hessian_apply_core oha_checker u_chk
(
    .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_value(out_ch.result_value), .out_last(out_ch.last),
    .out_err(out_ch.layout_error), .out_index(out_ch.result_index)
);
